FILE: hw/rtl/tbar_pkg.sv
// Shared field widths and operation codes for the traffic bin accumulate and rank block.
package tbar_pkg;

  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned SIGNAL_W = 5;
  localparam int unsigned CARS_W   = 16;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned TOTAL_W  = 32;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

endpackage

FILE: hw/rtl/tbar_if.sv
// Item and result channel interfaces of the traffic bin accumulate and rank block.
interface tbar_in_if;
  import tbar_pkg::*;

  logic                valid;
  logic                ready;
  logic                opcode;
  logic [HOUR_W-1:0]   hour;
  logic [SIGNAL_W-1:0] signal_id;
  logic [CARS_W-1:0]   cars;
  logic [COUNT_W-1:0]  count_wanted;

  modport source (output valid, opcode, hour, signal_id, cars, count_wanted, input ready);
  modport sink   (input valid, opcode, hour, signal_id, cars, count_wanted, output ready);
endinterface

interface tbar_out_if;
  import tbar_pkg::*;

  logic                valid;
  logic                ready;
  logic [SIGNAL_W-1:0] rank_signal;
  logic [TOTAL_W-1:0]  rank_total;
  logic                bad_query;
  logic                last_of_answer;

  modport source (output valid, rank_signal, rank_total, bad_query, last_of_answer,
                  input ready);
  modport sink   (input valid, rank_signal, rank_total, bad_query, last_of_answer,
                  output ready);
endinterface

FILE: hw/rtl/tbar_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tbar_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 768
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hw/rtl/traffic_bin_accumulate_rank.sv
// Top level: hour-by-signal car totals in one RAM, with a top-N query per hour.
// Record: read the bin, then write the saturated sum back.
// Query of N signals: each rank is one full scan of the hour's row through the RAM
// read port, then a load of the result register.
// Bad query: one result flagged bad, with no scan. Query for zero signals: no result.
// After reset all HOURS * 2**clog2(SIGNS) RAM words are zeroed; no item is taken then.
module traffic_bin_accumulate_rank #(
  parameter int unsigned HOURS = 24,
  parameter int unsigned SIGNS = 24
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tbar_in_if.sink    item_i,
  tbar_out_if.source result_o
);
  import tbar_pkg::*;

  localparam int unsigned SIG_W = $clog2(SIGNS);
  localparam int unsigned HR_W  = (HOURS > 1) ? $clog2(HOURS) : 1;
  localparam int unsigned DEPTH = HOURS * (2 ** SIG_W);
  localparam int unsigned AW    = $clog2(DEPTH);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_REC   = 5'b00100,
    S_SCAN  = 5'b01000,
    S_PUT   = 5'b10000
  } state_e;

  state_e               state_q, state_d;
  logic [AW-1:0]        clr_q;
  logic [AW-1:0]        wr_addr_q;
  logic [CARS_W-1:0]    cars_q;
  logic [HR_W-1:0]      qrow_q;
  logic [COUNT_W-1:0]   left_q;
  logic [SIG_W-1:0]     sc_q;
  logic                 iss_q;
  logic                 cmp_vld_q;
  logic [SIG_W-1:0]     cmp_sig_q;
  logic                 found_q;
  logic [SIG_W-1:0]     best_sig_q;
  logic [TOTAL_W-1:0]   best_tot_q;
  logic [SIGNS-1:0]     taken_q;
  logic                 bad_q;
  logic                 ov_q;
  logic [SIGNAL_W-1:0]  o_sig_q;
  logic [TOTAL_W-1:0]   o_tot_q;
  logic                 o_bad_q;
  logic                 o_last_q;

  logic [HR_W-1:0]      row_tab [32];
  logic                 acc;
  logic                 is_rec;
  logic                 sig_ok;
  logic                 q_bad;
  logic                 q_empty;
  logic                 put_go;
  logic                 last_put;
  logic                 better;
  logic                 scan_start;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [TOTAL_W-1:0]   ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [TOTAL_W-1:0]   ram_rdata;
  logic [TOTAL_W:0]     sum;
  logic [TOTAL_W-1:0]   sat_sum;

  for (genvar g = 0; g < 32; g++) begin : g_row_tab
    assign row_tab[g] = HR_W'(g % HOURS);
  end

  assign item_i.ready = (state_q == S_IDLE);
  assign acc      = item_i.valid && item_i.ready;
  assign is_rec   = (item_i.opcode == OP_RECORD);
  assign sig_ok   = {1'b0, item_i.signal_id} < 6'(SIGNS);
  assign q_bad    = ({1'b0, item_i.hour} >= 6'(HOURS)) ||
                    ({1'b0, item_i.count_wanted} > 6'(SIGNS));
  assign q_empty  = (item_i.count_wanted == '0);
  assign put_go   = (state_q == S_PUT) && (!ov_q || result_o.ready);
  assign last_put = bad_q || (left_q == COUNT_W'(1));
  assign better   = cmp_vld_q && !taken_q[cmp_sig_q] && (!found_q || ram_rdata > best_tot_q);
  assign scan_start = (acc && !is_rec && !q_bad && !q_empty) || (put_go && !last_put);

  assign sum     = {1'b0, ram_rdata} + (TOTAL_W + 1)'(cars_q);
  assign sat_sum = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];

  assign ram_we    = (state_q == S_CLEAR) || (state_q == S_REC);
  assign ram_waddr = (state_q == S_CLEAR) ? clr_q : wr_addr_q;
  assign ram_wdata = (state_q == S_CLEAR) ? '0 : sat_sum;
  assign ram_raddr = (state_q == S_SCAN) ? AW'({qrow_q, sc_q}) :
                     AW'({row_tab[item_i.hour], item_i.signal_id[SIG_W-1:0]});

  tbar_ram #(
    .WIDTH(TOTAL_W),
    .DEPTH(DEPTH)
  ) u_bins (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_q == AW'(DEPTH - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (acc) begin
          if (is_rec) begin
            if (sig_ok) state_d = S_REC;
          end else if (q_bad) begin
            state_d = S_PUT;
          end else if (!q_empty) begin
            state_d = S_SCAN;
          end
        end
      end
      S_REC: state_d = S_IDLE;
      S_SCAN: begin
        if (cmp_vld_q && !iss_q) state_d = S_PUT;
      end
      S_PUT: begin
        if (put_go) state_d = last_put ? S_IDLE : S_SCAN;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      iss_q     <= 1'b0;
      cmp_vld_q <= 1'b0;
      found_q   <= 1'b0;
      taken_q   <= '0;
      bad_q     <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + AW'(1);

      if (acc && !is_rec) begin
        bad_q   <= q_bad;
        taken_q <= '0;
      end else if (put_go && !bad_q) begin
        taken_q[best_sig_q] <= 1'b1;
      end

      if (scan_start) begin
        iss_q     <= 1'b1;
        cmp_vld_q <= 1'b0;
        found_q   <= 1'b0;
      end else if (state_q == S_SCAN) begin
        cmp_vld_q <= iss_q;
        if (iss_q && sc_q == '0) iss_q <= 1'b0;
        if (better) found_q <= 1'b1;
      end

      if (put_go) begin
        ov_q <= 1'b1;
      end else if (result_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      wr_addr_q <= ram_raddr;
      cars_q    <= item_i.cars;
      qrow_q    <= HR_W'(item_i.hour);
      left_q    <= item_i.count_wanted;
    end else if (put_go) begin
      left_q <= left_q - COUNT_W'(1);
    end

    if (scan_start) begin
      sc_q <= SIG_W'(SIGNS - 1);
    end else if (state_q == S_SCAN && iss_q) begin
      cmp_sig_q <= sc_q;
      if (sc_q != '0) sc_q <= sc_q - SIG_W'(1);
    end

    if (better) begin
      best_sig_q <= cmp_sig_q;
      best_tot_q <= ram_rdata;
    end

    if (put_go) begin
      o_sig_q  <= bad_q ? '0 : SIGNAL_W'(best_sig_q);
      o_tot_q  <= bad_q ? '0 : best_tot_q;
      o_bad_q  <= bad_q;
      o_last_q <= last_put;
    end
  end

  assign result_o.valid          = ov_q;
  assign result_o.rank_signal    = o_sig_q;
  assign result_o.rank_total     = o_tot_q;
  assign result_o.bad_query      = o_bad_q;
  assign result_o.last_of_answer = o_last_q;

  a_put_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUT && !bad_q) |-> found_q)
    else $error("rank result without a chosen signal");

  a_put_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUT && !bad_q) |-> !taken_q[best_sig_q])
    else $error("signal ranked twice in one answer");

  a_scan_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> ($countones(taken_q) < SIGNS))
    else $error("scan started with every signal taken");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (put_go && last_put) |=> (state_q == S_IDLE))
    else $error("answer did not end after its last item");

endmodule
